// File: design/cphd_pkg.sv
// Shared constants for the contact peak hit detector: register map, field widths, reset values.
package cphd_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;

  localparam int STEP_BITS      = 8;
  localparam int PEAK_TICK_BITS = 4;
  localparam int COUNT_BITS     = 5;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [STEP_BITS-1:0]      step_t;
  typedef logic [PEAK_TICK_BITS-1:0] peak_tick_t;
  typedef logic [COUNT_BITS-1:0]     count_t;

  localparam cfg_index_t REG_BASELINE_STEP   = 2'd0;
  localparam cfg_index_t REG_FIRST_PEAK_TICK = 2'd1;
  localparam cfg_index_t REG_DECISION_TICK   = 2'd2;

  localparam step_t      BASELINE_STEP_RESET   = 8'd13;
  localparam peak_tick_t FIRST_PEAK_TICK_RESET = 4'd3;
  localparam count_t     DECISION_TICK_RESET   = 5'd10;

  localparam count_t     COUNT_MAX  = 5'd31;
  localparam count_t     CLEAR_LAST = 5'd2;

  localparam int BASE_RESET_INT = 1000;

endpackage

// File: design/contact_peak_hit_detector_top.sv
// Top level of the contact peak hit detector: tick counter, baseline tracker, peak hold, skid output.
// An accepted beat's result is registered into the output stage, or into the skid stage on a stall.
// Throughput: one beat per cycle unless the skid is full; all per-tick work is a single add/compare
// pass into the result register, with a one-entry skid stage so input is taken while a result waits.
// Reset (rst, synchronous, active high): counter 0, peak hold 0, baseline 1000 in fixed point,
// registers at baseline_step 13, first_peak_tick 3, decision_tick 10; both stages empty.
module contact_peak_hit_detector_top #(
  parameter int SAMPLE_BITS   = 12,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // tip_coupled [0], sample [SAMPLE_BITS:1], zero fill
  input  logic [((SAMPLE_BITS+1+7)/8)*8-1:0]     s_tdata,
  // sample_late [0]
  input  logic                                   s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // hit [0], held_value, baseline_level, coupled_ticks, zero fill
  output logic [((2*SAMPLE_BITS+FRACTION_BITS+6+7)/8)*8-1:0] m_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cphd_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [cphd_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import cphd_pkg::*;

  localparam int BASE_BITS = SAMPLE_BITS + FRACTION_BITS;
  localparam int OUT_BITS  = 1 + SAMPLE_BITS + BASE_BITS + COUNT_BITS;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
  localparam logic [BASE_BITS-1:0] BASE_RESET =
    BASE_BITS'(64'(BASE_RESET_INT) << FRACTION_BITS);

  step_t      baseline_step;
  peak_tick_t first_peak_tick;
  count_t     decision_tick;

  count_t                 tick_counter;
  logic [BASE_BITS-1:0]   baseline;
  logic [SAMPLE_BITS-1:0] peak_hold;

  count_t                 tick_counter_next;
  logic [BASE_BITS-1:0]   baseline_next;
  logic [SAMPLE_BITS-1:0] peak_hold_next;
  logic                   hit_next;

  logic                   in_coupled;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   in_late;
  logic                   in_beat;

  count_t                 cap;
  count_t                 cnt;
  logic [BASE_BITS:0]     base_up;
  logic [BASE_BITS-1:0]   sample_q;
  logic [BASE_BITS-1:0]   peak_q;

  logic                   out_hit;
  logic [SAMPLE_BITS-1:0] out_held;
  logic [BASE_BITS-1:0]   out_base;
  count_t                 out_ticks;

  logic                   skid_valid;
  logic                   skid_hit;
  logic [SAMPLE_BITS-1:0] skid_held;
  logic [BASE_BITS-1:0]   skid_base;
  count_t                 skid_ticks;

  assign in_coupled = s_tdata[0];
  assign in_sample  = s_tdata[SAMPLE_BITS:1];
  assign in_late    = s_tuser;
  assign s_tready   = !skid_valid;
  assign in_beat    = s_tvalid && s_tready;
  assign cfg_ready  = 1'b1;

  assign m_tdata = OUT_W'({out_ticks, out_base, out_held, out_hit});

  always_comb begin
    cap = (decision_tick >= COUNT_MAX - 5'd1) ? COUNT_MAX : decision_tick + 5'd1;
    if (!in_coupled) begin
      cnt = '0;
    end else if (tick_counter >= cap) begin
      cnt = cap;
    end else begin
      cnt = tick_counter + 5'd1;
    end

    sample_q = {in_sample, {FRACTION_BITS{1'b0}}};
    peak_q   = {peak_hold, {FRACTION_BITS{1'b0}}};
    base_up  = {1'b0, baseline} + (BASE_BITS+1)'(baseline_step);

    tick_counter_next = tick_counter;
    baseline_next     = baseline;
    peak_hold_next    = peak_hold;
    hit_next          = 1'b0;

    if (in_late) begin
      if (!in_coupled) begin
        tick_counter_next = '0;
      end
    end else begin
      tick_counter_next = cnt;
      if (cnt == '0) begin
        peak_hold_next = in_sample;
        if (sample_q > baseline) begin
          baseline_next = base_up[BASE_BITS] ? '1 : base_up[BASE_BITS-1:0];
        end else if (baseline >= BASE_BITS'(baseline_step)) begin
          baseline_next = baseline - BASE_BITS'(baseline_step);
        end else begin
          baseline_next = '0;
        end
      end else if (cnt == decision_tick) begin
        hit_next = (peak_q < baseline);
      end else if (cnt <= CLEAR_LAST) begin
        peak_hold_next = '0;
      end else if (cnt >= COUNT_BITS'(first_peak_tick) && cnt < decision_tick) begin
        if (in_sample > peak_hold) begin
          peak_hold_next = in_sample;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_step   <= BASELINE_STEP_RESET;
      first_peak_tick <= FIRST_PEAK_TICK_RESET;
      decision_tick   <= DECISION_TICK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASELINE_STEP:   baseline_step   <= cfg_data[STEP_BITS-1:0];
        REG_FIRST_PEAK_TICK: first_peak_tick <= cfg_data[PEAK_TICK_BITS-1:0];
        REG_DECISION_TICK:   decision_tick   <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      baseline     <= BASE_RESET;
      peak_hold    <= '0;
    end else if (in_beat) begin
      tick_counter <= tick_counter_next;
      baseline     <= baseline_next;
      peak_hold    <= peak_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!in_beat) begin
        m_tvalid <= 1'b0;
      end
    end else if (!m_tvalid) begin
      if (in_beat) begin
        m_tvalid <= 1'b1;
      end
    end else if (in_beat) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tvalid && m_tready && skid_valid) begin
      out_hit   <= skid_hit;
      out_held  <= skid_held;
      out_base  <= skid_base;
      out_ticks <= skid_ticks;
    end else if (in_beat && (!m_tvalid || m_tready)) begin
      out_hit   <= hit_next;
      out_held  <= peak_hold_next;
      out_base  <= baseline_next;
      out_ticks <= tick_counter_next;
    end
    if (in_beat && m_tvalid && !m_tready) begin
      skid_hit   <= hit_next;
      skid_held  <= peak_hold_next;
      skid_base  <= baseline_next;
      skid_ticks <= tick_counter_next;
    end
  end

  a_hit_on_decision: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_hit |-> out_ticks == decision_tick && out_ticks != '0)
    else $error("hit beat not on decision tick");

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid stage full while output empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    in_beat && m_tvalid && !m_tready |=> skid_valid && m_tvalid)
    else $error("beat taken during stall was not held");

endmodule
